>>> src/grid_to_particle_transfer_assert.svh
// Assertion macros for the grid-to-particle transfer block
`ifndef GRID_TO_PARTICLE_TRANSFER_ASSERT_SVH
`define GRID_TO_PARTICLE_TRANSFER_ASSERT_SVH

// antecedent implies consequent in the same cycle, outside reset
`define G2P_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("g2p assertion failed");

// antecedent implies consequent in the next cycle, outside reset
`define G2P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("g2p assertion failed");

// checked also while reset is high
`define G2P_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("g2p reset assertion failed");

`endif

>>> src/g2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package g2p_pkg;
  localparam int unsigned SupportNodesDef = 27;
  localparam int unsigned InDataW = 280;
  localparam int unsigned OutDataW = 264;
  localparam logic [31:0] StepTimeRst = 32'd429497;
  localparam logic [39:0] InvInertiaRst = 40'd2621440000;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NODE = 1'b1;
  localparam logic [1:0] REG_STEP_TIME = 2'd0;
  localparam logic [1:0] REG_INV_INERTIA = 2'd1;
  localparam logic [1:0] ROW_LAST = 2'd2;
  localparam logic [3:0] NODE_STEPS = 4'd9;
  localparam logic [3:0] NODE_DRAIN = 4'd10;
  localparam logic [3:0] MAT_LAST = 4'd8;

  typedef struct packed {
    logic       load;
    logic       node;
    logic       coef;
    logic       issue;
    logic       mat;
    logic       grad;
    logic       vel;
    logic       clear;
    logic [3:0] step;
  } g2p_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
    if (x > 80'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -80'sh8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [79:0] x);
    if (x > 80'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (x < -80'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return x[47:0];
  endfunction

  function automatic logic signed [79:0] rsh16(input logic signed [79:0] x);
    return (x + 80'sd32768) >>> 16;
  endfunction

  function automatic logic signed [79:0] rsh32(input logic signed [79:0] x);
    return (x + 80'sh8000_0000) >>> 32;
  endfunction

  function automatic logic [1:0] row_of(input logic [3:0] k);
    unique case (k)
      4'd0, 4'd1, 4'd2: return 2'd0;
      4'd3, 4'd4, 4'd5: return 2'd1;
      4'd6, 4'd7, 4'd8: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] k);
    unique case (k)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      4'd2, 4'd5, 4'd8: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> src/g2p_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module g2p_ctrl import g2p_pkg::*; #(
  parameter int unsigned SUPPORT_NODES = SupportNodesDef
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire logic     in_kind,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output logic          m_tlast,
  output g2p_cmd_t      cmd
);
  localparam int unsigned NcW = $clog2(SUPPORT_NODES + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_COEF = 7'b0000010,
    S_NODE = 7'b0000100,
    S_MAT  = 7'b0001000,
    S_GRAD = 7'b0010000,
    S_VEL  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t         state, state_next;
  logic [3:0]     step, step_next;
  logic [NcW-1:0] node_cnt, node_cnt_next;
  logic           accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = (state == S_OUT) && (step[1:0] == ROW_LAST);

  always_comb begin
    state_next    = state;
    step_next     = step;
    node_cnt_next = node_cnt;
    unique case (state)
      S_IDLE: begin
        if (accept && in_kind == CMD_NODE) state_next = S_COEF;
      end
      S_COEF: begin
        state_next = S_NODE;
        step_next  = 4'd0;
      end
      S_NODE: begin
        step_next = step + 4'd1;
        if (step == NODE_DRAIN) begin
          step_next = 4'd0;
          if (node_cnt == NcW'(SUPPORT_NODES - 1)) begin
            state_next = S_MAT;
          end else begin
            node_cnt_next = node_cnt + NcW'(1);
            state_next    = S_IDLE;
          end
        end
      end
      S_MAT: begin
        step_next = step + 4'd1;
        if (step == MAT_LAST) begin
          step_next  = 4'd0;
          state_next = S_GRAD;
        end
      end
      S_GRAD: begin
        step_next = step + 4'd1;
        if (step == MAT_LAST) begin
          step_next  = 4'd0;
          state_next = S_VEL;
        end
      end
      S_VEL: begin
        step_next = step + 4'd1;
        if (step[1:0] == ROW_LAST) begin
          step_next  = 4'd0;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (m_tready) begin
          step_next = step + 4'd1;
          if (step[1:0] == ROW_LAST) begin
            step_next     = 4'd0;
            node_cnt_next = '0;
            state_next    = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= 4'd0;
      node_cnt <= '0;
    end else begin
      state    <= state_next;
      step     <= step_next;
      node_cnt <= node_cnt_next;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.load  = accept && (in_kind == CMD_LOAD);
    cmd.node  = accept && (in_kind == CMD_NODE);
    cmd.coef  = (state == S_COEF);
    cmd.issue = (state == S_NODE) && (step < NODE_STEPS);
    cmd.mat   = (state == S_MAT);
    cmd.grad  = (state == S_GRAD);
    cmd.vel   = (state == S_VEL);
    cmd.clear = (state == S_OUT) && m_tready && (step[1:0] == ROW_LAST);
    cmd.step  = step;
  end
endmodule
`default_nettype wire

>>> src/g2p_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module g2p_datapath import g2p_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire g2p_cmd_t            cmd,
  input  wire logic [InDataW-1:0]  s_tdata,
  output logic [OutDataW-1:0]      m_tdata,
  input  wire logic                cfg_valid,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [39:0]         cfg_data
);
  logic [31:0] step_time;
  logic [39:0] inv_inertia;

  logic signed [31:0] grad_q [9];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] oldvel_q [3];
  logic               frozen_q;
  logic signed [47:0] vel_acc [3];
  logic signed [47:0] aff_acc [9];

  logic signed [31:0] v_q [3];
  logic signed [31:0] np_q [3];
  logic        [16:0] w_q;
  logic        [30:0] coef_q;
  logic signed [31:0] d_q [3];

  logic               v1, v2;
  logic        [3:0]  k1, k2;
  logic signed [31:0] p_q;
  logic signed [47:0] term_q;
  logic signed [49:0] vt_q;

  logic signed [31:0] m_q [9];
  logic signed [31:0] grad_o [9];
  logic signed [31:0] vel_o [3];
  logic signed [31:0] pos_o [3];

  logic [1:0]          in_row;
  logic [3:0]          in_base;
  logic signed [31:0]  in_vec [3];
  logic signed [31:0]  in_np [3];
  logic [16:0]         in_w;
  logic [56:0]         cprod;
  logic [40:0]         cround;
  logic signed [63:0]  pprod;
  logic signed [63:0]  tprod;
  logic signed [49:0]  wprod;
  logic signed [31:0]  aff_k;
  logic signed [64:0]  mprod;
  logic signed [79:0]  mval;
  logic [1:0]          gr, gc;
  logic [3:0]          gbase;
  logic signed [63:0]  gp0, gp1, gp2;
  logic signed [79:0]  gsum;
  logic [1:0]          vr;
  logic signed [31:0]  vel_sel;
  logic signed [64:0]  dprod;
  logic [1:0]          orow;
  logic [3:0]          obase;
  logic signed [31:0]  aff_out [3];

  assign in_row    = s_tdata[1:0];
  assign in_base   = {1'b0, in_row, 1'b0} + {2'b00, in_row};
  assign in_vec[0] = s_tdata[33:2];
  assign in_vec[1] = s_tdata[65:34];
  assign in_vec[2] = s_tdata[97:66];
  assign in_w      = s_tdata[179:163];
  assign in_np[0]  = s_tdata[211:180];
  assign in_np[1]  = s_tdata[243:212];
  assign in_np[2]  = s_tdata[275:244];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= StepTimeRst;
      inv_inertia <= InvInertiaRst;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STEP_TIME) step_time <= cfg_data[31:0];
      if (cfg_index == REG_INV_INERTIA) inv_inertia <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_row != 2'd3) begin
      for (int c = 0; c < 3; c++) grad_q[in_base + 4'(c)] <= in_vec[c];
      pos_q[in_row]    <= s_tdata[129:98];
      oldvel_q[in_row] <= s_tdata[161:130];
    end
    if (cmd.node) begin
      v_q  <= in_vec;
      np_q <= in_np;
      w_q  <= (in_w > 17'd65536) ? 17'd65536 : in_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) frozen_q <= 1'b0;
    else if (cmd.load && in_row != 2'd3) frozen_q <= s_tdata[162];
  end

  assign cprod  = w_q * inv_inertia;
  assign cround = 41'((58'(cprod) + 58'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (cmd.coef) begin
      coef_q <= (cround > 41'h7FFF_FFFF) ? 31'h7FFF_FFFF : cround[30:0];
      for (int c = 0; c < 3; c++) begin
        d_q[c] <= sat32(80'(np_q[c]) - 80'(pos_q[c]));
      end
    end
  end

  assign pprod = v_q[row_of(cmd.step)] * d_q[col_of(cmd.step)];
  assign tprod = $signed({1'b0, coef_q}) * p_q;
  assign wprod = $signed({1'b0, w_q}) * v_q[row_of(k1)];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p_q    <= sat32(rsh16(80'(pprod)));
    k1     <= cmd.step;
    term_q <= sat48(80'(tprod));
    vt_q   <= wprod;
    k2     <= k1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 3; i++) vel_acc[i] <= '0;
      for (int i = 0; i < 9; i++) aff_acc[i] <= '0;
    end else if (v2) begin
      aff_acc[k2] <= sat48(80'(aff_acc[k2]) + 80'(term_q));
      if (col_of(k2) == 2'd0) begin
        vel_acc[row_of(k2)] <= sat48(80'(vel_acc[row_of(k2)]) + 80'(vt_q));
      end
    end
  end

  assign aff_k = sat32(rsh16(80'(aff_acc[cmd.step])));
  assign mprod = $signed({1'b0, step_time}) * aff_k;
  assign mval  = rsh32(80'(mprod)) +
                 ((row_of(cmd.step) == col_of(cmd.step)) ? 80'sd65536 : 80'sd0);

  assign gr    = row_of(cmd.step);
  assign gc    = col_of(cmd.step);
  assign gbase = {1'b0, gr, 1'b0} + {2'b00, gr};
  assign gp0   = m_q[gbase] * grad_q[{2'b00, gc}];
  assign gp1   = m_q[gbase + 4'd1] * grad_q[4'd3 + {2'b00, gc}];
  assign gp2   = m_q[gbase + 4'd2] * grad_q[4'd6 + {2'b00, gc}];
  assign gsum  = rsh16(80'(gp0)) + rsh16(80'(gp1)) + rsh16(80'(gp2));

  assign vr      = cmd.step[1:0];
  assign vel_sel = frozen_q ? oldvel_q[vr] : sat32(rsh16(80'(vel_acc[vr])));
  assign dprod   = $signed({1'b0, step_time}) * vel_sel;

  always_ff @(posedge clk) begin
    if (cmd.mat) m_q[cmd.step] <= sat32(mval);
    if (cmd.grad) grad_o[cmd.step] <= sat32(gsum);
    if (cmd.vel) begin
      vel_o[vr] <= vel_sel;
      pos_o[vr] <= sat32(80'(pos_q[vr]) + rsh32(80'(dprod)));
    end
  end

  assign orow  = cmd.step[1:0];
  assign obase = {1'b0, orow, 1'b0} + {2'b00, orow};
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      aff_out[c] = sat32(rsh16(80'(aff_acc[obase + 4'(c)])));
    end
  end

  assign m_tdata = {6'd0, pos_o[orow], vel_o[orow],
                    aff_out[2], aff_out[1], aff_out[0],
                    grad_o[obase + 4'd2], grad_o[obase + 4'd1], grad_o[obase], orow};
endmodule
`default_nettype wire

>>> src/grid_to_particle_transfer.sv
// Load request: stored when accepted. Node request: a coefficient step, then a
// 3-stage multiply-accumulate pipeline over the 9 affine terms; no new request
// is taken until it ends. After the last node request come 9 matrix, 9 gradient
// and 3 velocity steps; then 3 result rows are offered, one per accepted cycle.
// Synchronous reset clears control, accumulators, frozen flag; sets config regs.
`timescale 1ns / 1ps
`default_nettype none
module grid_to_particle_transfer import g2p_pkg::*; #(
  parameter int unsigned SUPPORT_NODES = SupportNodesDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // row_index, vec_x, vec_y, vec_z, pos_comp, vel_comp, frozen, weight,
  // node_pos_x, node_pos_y, node_pos_z
  input  wire logic [InDataW-1:0]  s_tdata,
  // cmd
  input  wire logic [0:0]          s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // out_row, grad_c0, grad_c1, grad_c2, aff_c0, aff_c1, aff_c2, new_vel, new_pos
  output logic [OutDataW-1:0]      m_tdata,
  output logic                     m_tlast,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [39:0]         cfg_data
);
  g2p_cmd_t cmd;

  assign cfg_ready = 1'b1;

  g2p_ctrl #(.SUPPORT_NODES(SUPPORT_NODES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_kind  (s_tuser[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd)
  );

  g2p_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );
endmodule
`default_nettype wire

>>> src/g2p_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "grid_to_particle_transfer_assert.svh"
module g2p_chk import g2p_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic                m_tlast,
  input wire logic [OutDataW-1:0] m_tdata
);
  `G2P_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready)
  `G2P_ASSERT_SAME(a_last_row, m_tvalid && m_tlast, m_tdata[1:0] == ROW_LAST)
  `G2P_ASSERT_RST(a_reset_quiet, rst, !m_tvalid && s_tready)
  `G2P_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind grid_to_particle_transfer g2p_chk u_chk (.*);
`default_nettype wire
